### sv/mcg_pkg.sv
// shared types, constants and tables for the month calendar grid block
`timescale 1ns / 1ps

package mcg_pkg;

  typedef logic [3:0]  month_t;
  typedef logic [11:0] year_t;
  typedef logic [4:0]  day_t;
  typedef logic [2:0]  pos_t;
  typedef logic [12:0] dsum_t;

  typedef enum logic [1:0] {
    CELL_PREV = 2'd0,
    CELL_CUR  = 2'd1,
    CELL_NEXT = 2'd2
  } cell_month_e;

  localparam month_t MonthJan = 4'd1;
  localparam month_t MonthFeb = 4'd2;
  localparam month_t MonthDec = 4'd12;
  localparam year_t  YearMin  = 12'd1583;

  localparam int unsigned NumRows = 6;
  localparam int unsigned NumCols = 7;
  localparam pos_t LastRow  = 3'(NumRows - 1);
  localparam pos_t LastCol  = 3'(NumCols - 1);
  localparam pos_t FirstWeekendCol = 3'd5;

  // reciprocal constants for division by 100 and by 7
  localparam logic [12:0] Recip100      = 13'd5243;
  localparam int unsigned Recip100Shift = 19;
  localparam logic [13:0] Recip7        = 14'd9363;
  localparam int unsigned Recip7Shift   = 16;

  // one job handed from the front to the back
  typedef struct packed {
    month_t      mon;
    day_t        day;
    cell_month_e rel;
    logic        leap;
    day_t        today;
  } mcg_job_t;

  // days in a month, leap selects 29 for february
  function automatic day_t month_len(input month_t mon, input logic leap);
    day_t len;
    unique case (mon)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // (31 * m) / 12 with m counted from march = 1
  function automatic day_t month_shift(input month_t mon);
    day_t sh;
    unique case (mon)
      4'd3:    sh = 5'd2;
      4'd4:    sh = 5'd5;
      4'd5:    sh = 5'd7;
      4'd6:    sh = 5'd10;
      4'd7:    sh = 5'd12;
      4'd8:    sh = 5'd15;
      4'd9:    sh = 5'd18;
      4'd10:   sh = 5'd20;
      4'd11:   sh = 5'd23;
      4'd12:   sh = 5'd25;
      4'd1:    sh = 5'd28;
      4'd2:    sh = 5'd31;
      default: sh = 5'd0;
    endcase
    return sh;
  endfunction

endpackage

### sv/mcg_if.sv
// valid/ready channel interfaces for requests and grid cells
`timescale 1ns / 1ps

interface mcg_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  month_in;
  logic [11:0] year_in;
  logic [4:0]  today_day;

  modport source(output valid, output month_in, output year_in, output today_day,
                 input ready);
  modport sink(input valid, input month_in, input year_in, input today_day,
               output ready);
endinterface

interface mcg_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] grid_row;
  logic [2:0] grid_col;
  logic [4:0] day_number;
  logic [1:0] cell_month;
  logic       is_weekend;
  logic       is_today;
  logic       last_cell;

  modport source(output valid, output grid_row, output grid_col, output day_number,
                 output cell_month, output is_weekend, output is_today,
                 output last_cell, input ready);
  modport sink(input valid, input grid_row, input grid_col, input day_number,
               input cell_month, input is_weekend, input is_today,
               input last_cell, output ready);
endinterface

### sv/mcg_front.sv
// front pipeline: clamps a request, finds the weekday of the 1st and the first cell
`timescale 1ns / 1ps

module mcg_front import mcg_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  mcg_in_if.sink   in_i,
  output logic     job_valid_o,
  input  logic     job_ready_i,
  output mcg_job_t job_o
);

  typedef struct packed {
    month_t mon;
    year_t  yr;
    year_t  yy;
    day_t   shift;
    day_t   today;
  } st1_t;

  typedef struct packed {
    month_t     mon;
    year_t      yr;
    year_t      yy;
    logic [5:0] q_yy;
    day_t       shift;
    day_t       today;
  } st2_t;

  typedef struct packed {
    month_t     mon;
    year_t      yr;
    dsum_t      s;
    logic [5:0] q_yr;
    day_t       today;
  } st3_t;

  typedef struct packed {
    month_t     mon;
    logic       leap;
    dsum_t      s;
    logic [9:0] q7;
    day_t       today;
  } st4_t;

  logic st1_v_q, st2_v_q, st3_v_q, st4_v_q;
  st1_t st1_q, st1_d;
  st2_t st2_q, st2_d;
  st3_t st3_q, st3_d;
  st4_t st4_q, st4_d;
  logic en;

  month_t      mon_c;
  year_t       yr_c;
  logic [24:0] prod_yy, prod_yr;
  logic [26:0] prod_7;
  logic        is100;
  dsum_t       rem_full;
  logic [2:0]  rem7, offset;
  month_t      prev_mon;
  day_t        prev_len;

  // whole pipeline holds while its last stage cannot hand over
  assign en          = !(st4_v_q && !job_ready_i);
  assign in_i.ready  = en;

  // stage 1: clamp, shift the year for january and february
  always_comb begin
    if (in_i.month_in < MonthJan) begin
      mon_c = MonthJan;
    end else if (in_i.month_in > MonthDec) begin
      mon_c = MonthDec;
    end else begin
      mon_c = in_i.month_in;
    end
    yr_c = (in_i.year_in < YearMin) ? YearMin : in_i.year_in;
    st1_d.mon   = mon_c;
    st1_d.yr    = yr_c;
    st1_d.yy    = yr_c - 12'((mon_c <= MonthFeb) ? 1 : 0);
    st1_d.shift = month_shift(mon_c);
    st1_d.today = in_i.today_day;
  end

  // stage 2: century count of the shifted year
  always_comb begin
    prod_yy     = 25'(st1_q.yy) * 25'(Recip100);
    st2_d.mon   = st1_q.mon;
    st2_d.yr    = st1_q.yr;
    st2_d.yy    = st1_q.yy;
    st2_d.q_yy  = prod_yy[Recip100Shift +: 6];
    st2_d.shift = st1_q.shift;
    st2_d.today = st1_q.today;
  end

  // stage 3: day-of-week sum, century count of the real year for the leap test
  always_comb begin
    prod_yr     = 25'(st2_q.yr) * 25'(Recip100);
    st3_d.mon   = st2_q.mon;
    st3_d.yr    = st2_q.yr;
    st3_d.s     = 13'd1 + {1'b0, st2_q.yy} + {3'b0, st2_q.yy[11:2]}
                - {7'b0, st2_q.q_yy} + {9'b0, st2_q.q_yy[5:2]} + {8'b0, st2_q.shift};
    st3_d.q_yr  = prod_yr[Recip100Shift +: 6];
    st3_d.today = st2_q.today;
  end

  // stage 4: quotient by 7, leap by the 4/100/400 rule
  always_comb begin
    prod_7      = 27'(st3_q.s) * 27'(Recip7);
    is100       = (st3_q.yr == 12'(12'(st3_q.q_yr) * 12'd100));
    st4_d.mon   = st3_q.mon;
    st4_d.leap  = (st3_q.yr[1:0] == 2'd0) && (!is100 || (st3_q.q_yr[1:0] == 2'd0));
    st4_d.s     = st3_q.s;
    st4_d.q7    = prod_7[Recip7Shift +: 10];
    st4_d.today = st3_q.today;
  end

  // hand-over: number of leading previous-month cells and the first cell
  always_comb begin
    rem_full = st4_q.s - 13'({3'b0, st4_q.q7} * 13'd7);
    rem7     = rem_full[2:0];
    offset   = (rem7 == 3'd0) ? 3'd6 : rem7 - 3'd1;
    prev_mon = (st4_q.mon == MonthJan) ? MonthDec : st4_q.mon - 4'd1;
    prev_len = month_len(prev_mon, st4_q.leap);
    job_o.leap  = st4_q.leap;
    job_o.today = st4_q.today;
    if (offset == 3'd0) begin
      job_o.mon = st4_q.mon;
      job_o.day = 5'd1;
      job_o.rel = CELL_CUR;
    end else begin
      job_o.mon = prev_mon;
      job_o.day = prev_len - {2'b0, offset} + 5'd1;
      job_o.rel = CELL_PREV;
    end
  end

  assign job_valid_o = st4_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st1_v_q <= 1'b0;
      st2_v_q <= 1'b0;
      st3_v_q <= 1'b0;
      st4_v_q <= 1'b0;
    end else if (en) begin
      st1_v_q <= in_i.valid;
      st2_v_q <= st1_v_q;
      st3_v_q <= st2_v_q;
      st4_v_q <= st3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      st1_q <= st1_d;
      st2_q <= st2_d;
      st3_q <= st3_d;
      st4_q <= st4_d;
    end
  end

endmodule

### sv/mcg_queue.sv
// small job queue between the front pipeline and the cell engine
`timescale 1ns / 1ps

module mcg_queue import mcg_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_valid_i,
  output logic     push_ready_o,
  input  mcg_job_t push_data_i,
  output logic     pop_valid_o,
  input  logic     pop_ready_i,
  output mcg_job_t pop_data_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  mcg_job_t            mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### sv/mcg_back.sv
// cell engine: walks the 42 grid cells of a job into a registered output word
`timescale 1ns / 1ps

module mcg_back import mcg_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     job_valid_i,
  output logic     job_ready_o,
  input  mcg_job_t job_i,
  mcg_out_if.source out_o
);

  logic        eng_v_q, eng_v_d;
  pos_t        row_q, row_d, col_q, col_d;
  mcg_job_t    eng_q, eng_d;
  logic        out_v_q;
  logic        adv, last, load;
  day_t        len;

  // output register
  pos_t        o_row_q, o_col_q;
  day_t        o_day_q;
  cell_month_e o_rel_q;
  logic        o_wkend_q, o_today_q, o_last_q;

  assign adv  = !out_v_q || out_o.ready;
  assign last = (row_q == LastRow) && (col_q == LastCol);
  assign len  = month_len(eng_q.mon, eng_q.leap);
  // take a new job when idle, or right behind the last cell of the current one
  assign load = adv && (!eng_v_q || last);
  assign job_ready_o = load;

  always_comb begin
    eng_v_d = eng_v_q;
    eng_d   = eng_q;
    row_d   = row_q;
    col_d   = col_q;
    if (load) begin
      eng_v_d = job_valid_i;
      eng_d   = job_i;
      row_d   = '0;
      col_d   = '0;
    end else if (eng_v_q && adv) begin
      if (col_q == LastCol) begin
        col_d = '0;
        row_d = row_q + 3'd1;
      end else begin
        col_d = col_q + 3'd1;
      end
      if (eng_q.day < len) begin
        eng_d.day = eng_q.day + 5'd1;
      end else begin
        eng_d.day = 5'd1;
        eng_d.mon = (eng_q.mon == MonthDec) ? MonthJan : eng_q.mon + 4'd1;
        eng_d.rel = (eng_q.rel == CELL_PREV) ? CELL_CUR : CELL_NEXT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eng_v_q <= 1'b0;
      out_v_q <= 1'b0;
      row_q   <= '0;
      col_q   <= '0;
    end else begin
      eng_v_q <= eng_v_d;
      row_q   <= row_d;
      col_q   <= col_d;
      if (adv) begin
        out_v_q <= eng_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    eng_q <= eng_d;
    if (adv) begin
      o_row_q   <= row_q;
      o_col_q   <= col_q;
      o_day_q   <= eng_q.day;
      o_rel_q   <= eng_q.rel;
      o_wkend_q <= (col_q >= FirstWeekendCol);
      o_today_q <= (eng_q.rel == CELL_CUR) && (eng_q.today != 5'd0)
                && (eng_q.day == eng_q.today);
      o_last_q  <= last;
    end
  end

  assign out_o.valid      = out_v_q;
  assign out_o.grid_row   = o_row_q;
  assign out_o.grid_col   = o_col_q;
  assign out_o.day_number = o_day_q;
  assign out_o.cell_month = o_rel_q;
  assign out_o.is_weekend = o_wkend_q;
  assign out_o.is_today   = o_today_q;
  assign out_o.last_cell  = o_last_q;

`ifndef SYNTHESIS
  // the last flag only ever marks the bottom-right cell
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && o_last_q |-> (o_row_q == LastRow) && (o_col_q == LastCol))
    else $error("last cell flag away from the final grid position");

  // a highlighted cell belongs to the current month
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && o_today_q |-> (o_rel_q == CELL_CUR))
    else $error("highlight outside the current month");

  // a job is only replaced after its final cell
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    eng_v_q && adv && !last |=> eng_v_q)
    else $error("cell engine dropped a job before its last cell");

  // a walked cell never shows day zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (o_day_q != 5'd0))
    else $error("grid cell with day number zero");
`endif

endmodule

### sv/month_calendar_grid_core.sv
// top level of the monday-first gregorian month calendar grid block
`timescale 1ns / 1ps

// Each request word (month, year, highlighted day) produces 42 cell words, a six-row by
// seven-column grid in row-major order starting on the Monday on or before the 1st,
// with the tail of the previous month before it and the start of the next month after.
// Months outside 1..12 clamp to the nearest end, years below 1583 clamp to 1583.
// Throughput is one cell word per cycle while the sink does not stall; that rate is set
// by the cell engine, which walks one grid position per cycle into the output register.
// Requests are taken while earlier grids are still going out: a four-stage front pipeline
// computes the weekday of the 1st and the leap year, and a job queue of QueueDepth
// entries lets the front run ahead of the engine.
// QueueDepth must be at least 2.

module month_calendar_grid_core import mcg_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mcg_in_if.sink    in_i,
  mcg_out_if.source out_o
);

  // front to queue
  logic     f_valid, f_ready;
  mcg_job_t f_job;

  // queue to cell engine
  logic     b_valid, b_ready;
  mcg_job_t b_job;

  // clamping, weekday of the 1st, leap year, first cell of the grid
  mcg_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .job_valid_o (f_valid),
    .job_ready_i (f_ready),
    .job_o       (f_job)
  );

  // decouples the front pipeline from the 42-cell grid walk
  mcg_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (f_job),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_data_o   (b_job)
  );

  // one cell per cycle, held in the output register while the sink stalls
  mcg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (b_valid),
    .job_ready_o (b_ready),
    .job_i       (b_job),
    .out_o       (out_o)
  );

endmodule
